[rtl/ilir_pkg.sv]
package ilir_pkg;

  // Request commands
  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // What one storage cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

endpackage

[rtl/ilir_cell.sv]
module ilir_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  ilir_pkg::cell_op_e            op_i,
  input  logic signed [DATA_WIDTH-1:0]  load_i,
  input  logic signed [DATA_WIDTH-1:0]  lower_i,
  input  logic signed [DATA_WIDTH-1:0]  upper_i,
  output logic signed [DATA_WIDTH-1:0]  data_o
);

  logic signed [DATA_WIDTH-1:0] data_q;
  logic signed [DATA_WIDTH-1:0] data_d;

  // Next word: keep, take the request word, or take a neighbor's word
  always_comb begin
    case (op_i)
      ilir_pkg::CELL_LOAD:       data_d = load_i;
      ilir_pkg::CELL_SHIFT_UP:   data_d = lower_i;
      ilir_pkg::CELL_SHIFT_DOWN: data_d = upper_i;
      default:                   data_d = data_q;
    endcase
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/indexed_list_insert_remove_unit.sv]
// Ordered list of up to DEPTH signed words, held in a row of storage cells.
// Input channel: in_valid_i / in_stall_o carry cmd_i, position_i and value_i.
// Commands: get, set (returns old word), insert at position (later entries
// move up), remove at position (later entries move down, word returned).
// Output channel: out_valid_o / out_stall_i carry data_out_o, status_o and
// count_o, one result for every request.
// Result: registered, presented in the cycle after the input transfer.
// Throughput: one request per cycle while in_stall_o is low; every cell
// shifts in parallel, so the whole list moves in the cycle of the transfer.
// Stall: the output register holds its result while out_stall_i is high, and
// in_stall_o rises only while a held result is being stalled.
// Reset: the entry count clears to zero and no result is pending; the cell
// contents are not cleared, since no command reads past the count.
// Bad positions and inserts into a full list return an error status and
// leave the list unchanged.
module indexed_list_insert_remove_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int PW        = $clog2(DEPTH + 1),
  localparam int IW        = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [PW-1:0]                 position_i,
  input  logic signed [DATA_WIDTH-1:0]  value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  data_out_o,
  output logic [1:0]                    status_o,
  output logic [PW-1:0]                 count_o
);

  localparam logic [PW-1:0] FullCount = PW'(DEPTH);

  logic                          out_valid_q;
  logic                          out_valid_d;
  logic signed [DATA_WIDTH-1:0]  data_out_q;
  logic signed [DATA_WIDTH-1:0]  data_out_d;
  logic [1:0]                    status_q;
  logic [1:0]                    status_d;
  logic [PW-1:0]                 count_q;
  logic [PW-1:0]                 count_d;

  logic                          in_xfer;
  logic                          is_full;
  logic                          pos_ok;
  logic                          do_op;
  logic [1:0]                    req_status;
  logic signed [DATA_WIDTH-1:0]  rd_word;
  logic signed [DATA_WIDTH-1:0]  cell_data [DEPTH];

  // Handshake: accept while no held result is being stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Position and capacity checks
  assign is_full = (count_q == FullCount);
  assign pos_ok  = (cmd_i == ilir_pkg::CMD_INSERT) ? (position_i <= count_q)
                                                   : (position_i < count_q);

  always_comb begin
    if (!pos_ok) begin
      req_status = ilir_pkg::STATUS_RANGE;
    end else if (cmd_i == ilir_pkg::CMD_INSERT && is_full) begin
      req_status = ilir_pkg::STATUS_FULL;
    end else begin
      req_status = ilir_pkg::STATUS_OK;
    end
  end

  assign do_op = in_xfer && (req_status == ilir_pkg::STATUS_OK);

  // Row of cells; each one decodes its own action from the request
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PW-1:0] CellIdx = PW'(i);
    ilir_pkg::cell_op_e            cell_op;
    logic signed [DATA_WIDTH-1:0]  lower;
    logic signed [DATA_WIDTH-1:0]  upper;

    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    always_comb begin
      cell_op = ilir_pkg::CELL_HOLD;
      if (do_op) begin
        case (cmd_i)
          ilir_pkg::CMD_SET: begin
            if (position_i == CellIdx) cell_op = ilir_pkg::CELL_LOAD;
          end
          ilir_pkg::CMD_INSERT: begin
            if (position_i == CellIdx) begin
              cell_op = ilir_pkg::CELL_LOAD;
            end else if (CellIdx > position_i) begin
              cell_op = ilir_pkg::CELL_SHIFT_UP;
            end
          end
          ilir_pkg::CMD_REMOVE: begin
            if (CellIdx >= position_i) cell_op = ilir_pkg::CELL_SHIFT_DOWN;
          end
          default: begin
            cell_op = ilir_pkg::CELL_HOLD;
          end
        endcase
      end
    end

    ilir_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .load_i (value_i),
      .lower_i(lower),
      .upper_i(upper),
      .data_o (cell_data[i])
    );
  end

  // Word at the requested position (only used when the position is valid)
  assign rd_word = cell_data[position_i[IW-1:0]];

  // Result and count update
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    data_out_d  = data_out_q;
    status_d    = status_q;
    count_d     = count_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      status_d    = req_status;
      data_out_d  = '0;
      if (req_status == ilir_pkg::STATUS_OK) begin
        case (cmd_i)
          ilir_pkg::CMD_INSERT: count_d = count_q + 1'b1;
          ilir_pkg::CMD_REMOVE: begin
            count_d    = count_q - 1'b1;
            data_out_d = rd_word;
          end
          default: data_out_d = rd_word;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    data_out_q <= data_out_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

`ifndef SYNTHESIS
  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count above capacity");

  // A good insert grows the list by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_op && cmd_i == ilir_pkg::CMD_INSERT |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the list");

  // A good remove shrinks the list by one
  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_op && cmd_i == ilir_pkg::CMD_REMOVE |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not shrink the list");

  // A full status is only reported with a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ilir_pkg::STATUS_FULL |-> count_q == FullCount)
    else $error("full status with room left");

  // A rejected request leaves the count alone
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && req_status != ilir_pkg::STATUS_OK |=> $stable(count_q))
    else $error("rejected request changed the count");
`endif

endmodule

[tb/tb_indexed_list_insert_remove_unit.sv]
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove_unit;

  localparam int LIST_DEPTH  = 16;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    logic [1:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] value;
  } list_request_t;

  typedef struct {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [POS_W-1:0]         count;
  } list_result_t;

  // Clock, reset and block ports
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                cmd_i       = ilir_pkg::CMD_GET;
  logic [POS_W-1:0]          position_i  = '0;
  logic signed [WORD_W-1:0]  value_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [WORD_W-1:0]  data_out_o;
  logic [1:0]                status_o;
  logic [POS_W-1:0]          count_o;

  // Request queue for the driver, expected results for the monitor
  list_request_t pending_requests[$];
  list_result_t  expected_results[$];

  // Shadow copy of the list
  logic signed [WORD_W-1:0] list_words[LIST_DEPTH];
  int list_len = 0;

  // Entry count as seen by the request generator
  int gen_count = 0;
  bit grow_list = 1'b1;

  int send_idle_pct = 35;
  int recv_idle_pct = 68;
  int req_transfers = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;

  indexed_list_insert_remove_unit #(
    .DEPTH     (LIST_DEPTH),
    .DATA_WIDTH(WORD_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  // Apply one request to the shadow list and return the result it gives
  function automatic list_result_t apply_list_request(list_request_t rq);
    list_result_t res;
    int j;
    res.data   = '0;
    res.status = ilir_pkg::STATUS_OK;
    if (rq.cmd == ilir_pkg::CMD_INSERT) begin
      if (int'(rq.position) > list_len) begin
        res.status = ilir_pkg::STATUS_RANGE;
      end else if (list_len >= LIST_DEPTH) begin
        res.status = ilir_pkg::STATUS_FULL;
      end else begin
        for (j = list_len; j > int'(rq.position); j--) list_words[j] = list_words[j-1];
        list_words[rq.position] = rq.value;
        list_len++;
      end
    end else if (int'(rq.position) >= list_len) begin
      res.status = ilir_pkg::STATUS_RANGE;
    end else begin
      res.data = list_words[rq.position];
      if (rq.cmd == ilir_pkg::CMD_SET) begin
        list_words[rq.position] = rq.value;
      end else if (rq.cmd == ilir_pkg::CMD_REMOVE) begin
        for (j = int'(rq.position) + 1; j < list_len; j++) list_words[j-1] = list_words[j];
        list_len--;
      end
    end
    res.count = POS_W'(list_len);
    return res;
  endfunction

  // Queue one request and track the count it leaves behind
  task automatic add_request(input logic [1:0] op, input int pos,
                             input logic signed [WORD_W-1:0] word);
    list_request_t rq;
    rq.cmd      = op;
    rq.position = POS_W'(pos);
    rq.value    = word;
    pending_requests.push_back(rq);
    if (op == ilir_pkg::CMD_INSERT && pos <= gen_count && gen_count < LIST_DEPTH)
      gen_count++;
    else if (op == ilir_pkg::CMD_REMOVE && pos < gen_count)
      gen_count--;
  endtask

  // Mostly well-formed requests; the list is swept between empty and full
  task automatic queue_random_requests(input int n);
    logic [1:0] op;
    int pos;
    int pick;
    int ins_w;
    int rem_w;
    logic signed [WORD_W-1:0] word;
    for (int k = 0; k < n; k++) begin
      if (k % 48 == 0) grow_list = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: word = 32'sh7fff_ffff;
        1: word = 32'sh8000_0000;
        2: word = '0;
        3: word = -32'sd1;
        default: word = $urandom();
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: any command at any position
        op  = 2'($urandom_range(0, 3));
        pos = $urandom_range(0, LIST_DEPTH);
      end else begin
        ins_w = grow_list ? 50 : 15;
        rem_w = grow_list ? 15 : 50;
        pick  = $urandom_range(0, 99);
        if (gen_count == 0 || pick < ins_w) op = ilir_pkg::CMD_INSERT;
        else if (pick < ins_w + rem_w) op = ilir_pkg::CMD_REMOVE;
        else if (pick < ins_w + rem_w + 17) op = ilir_pkg::CMD_GET;
        else op = ilir_pkg::CMD_SET;
        pos = (op == ilir_pkg::CMD_INSERT) ? $urandom_range(0, gen_count)
                                           : $urandom_range(0, gen_count - 1);
      end
      add_request(op, pos, word);
    end
  endtask

  // Sender pause: wait until every queued request has its result back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    list_request_t rq;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= ilir_pkg::CMD_GET;
      position_i <= '0;
      value_i    <= '0;
    end else begin
      // transfer on the input channel
      if (in_valid_i && !in_stall_o) begin
        rq.cmd      = cmd_i;
        rq.position = position_i;
        rq.value    = value_i;
        expected_results.push_back(apply_list_request(rq));
        req_transfers <= req_transfers + 1;
      end
      // load the next request once the channel is free
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rq = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= rq.cmd;
          position_i <= rq.position;
          value_i    <= rq.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started at fixed points of the input stream
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (in_valid_i && !in_stall_o &&
                 (req_transfers == 300 || req_transfers == 1500)) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf(
            "result with nothing expected (data %0d status %0d count %0d)",
            data_out_o, status_o, count_o));
        end else begin
          exp_res = expected_results.pop_front();
          if (data_out_o !== exp_res.data)
            report_mismatch($sformatf("data_out %0d, expected %0d", data_out_o, exp_res.data));
          if (status_o !== exp_res.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, exp_res.status));
          if (count_o !== exp_res.count)
            report_mismatch($sformatf("count %0d, expected %0d", count_o, exp_res.count));
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty list, boundaries, shifts, fill to full, full inserts
    add_request(ilir_pkg::CMD_GET,    0, 32'sd5);
    add_request(ilir_pkg::CMD_INSERT, 1, 32'sd7);
    add_request(ilir_pkg::CMD_INSERT, 0, 32'sh7fff_ffff);
    add_request(ilir_pkg::CMD_INSERT, 1, 32'sh8000_0000);
    add_request(ilir_pkg::CMD_INSERT, 0, -32'sd1);
    add_request(ilir_pkg::CMD_SET,    1, 32'sh5555_5555);
    add_request(ilir_pkg::CMD_GET,    3, 32'sd0);
    add_request(ilir_pkg::CMD_REMOVE, 0, 32'sd0);
    add_request(ilir_pkg::CMD_SET,    2, 32'shaaaa_aaaa);
    add_request(ilir_pkg::CMD_REMOVE, 2, 32'sd0);
    for (int i = 0; i < 14; i++) begin
      add_request(ilir_pkg::CMD_INSERT,
                  (i % 3 == 0) ? 0 : (i % 3 == 1) ? gen_count : gen_count / 2,
                  32'sha5a5_0000 | i);
    end
    add_request(ilir_pkg::CMD_INSERT, LIST_DEPTH, 32'sd1);
    add_request(ilir_pkg::CMD_INSERT, 0, 32'sd1);
    add_request(ilir_pkg::CMD_GET,    LIST_DEPTH, 32'sd0);
    add_request(ilir_pkg::CMD_REMOVE, LIST_DEPTH - 1, 32'sd0);

    // Random, sender idles less than receiver
    queue_random_requests(560);
    wait_drained();

    // Random, receiver idles less than sender
    send_idle_pct = 68;
    recv_idle_pct = 35;
    queue_random_requests(560);
    wait_drained();

    // Random, no random idling on either side; the receiver hold-off at 1500 transfers falls here
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(560);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/indexed_list_insert_remove_unit.sv
tb/tb_indexed_list_insert_remove_unit.sv
